>>> hw/rtl/ascii_hex_frame_deframer_assert.svh
`ifndef ASCII_HEX_FRAME_DEFRAMER_ASSERT_SVH
`define ASCII_HEX_FRAME_DEFRAMER_ASSERT_SVH

// Checked while out of reset, sampled on the rising edge of clk.
`define AHFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define AHFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ahfd_pkg.sv
package ahfd_pkg;

  localparam logic [7:0]  START_BYTE       = 8'hDE;
  localparam logic [15:0] HEADER_BYTES     = 16'd6;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int TDATA_W = 80;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_CHECKSUM  = 3'd3,
    ERR_NON_HEX   = 3'd4
  } err_t;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_LEN_HI = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_HEADER = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CKSUM  = 6'b100000
  } phase_t;

  // One decoded request from the front: a completed byte or a bad character.
  typedef struct packed {
    logic       err;
    logic [7:0] value;
  } token_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] data_index;
    logic [7:0]  api_id;
    logic [7:0]  command;
    logic [7:0]  status_code;
    logic [7:0]  frame_number;
    logic [15:0] option_word;
    err_t        error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.nib = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.nib = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> hw/rtl/ahfd_front.sv
module ahfd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_char,
  output logic            in_ready,
  input  logic            q_full,
  output logic            push,
  output ahfd_pkg::token_t push_token
);
  import ahfd_pkg::*;

  logic       pending_r, pending_nxt;
  logic [3:0] high_r, high_nxt;
  hex_t       hex;
  logic       accept;

  assign in_ready = !q_full;
  assign hex      = hex_decode(in_char);
  assign accept   = in_valid && in_ready;

  // A bad character always goes out; a digit only when it closes a pair.
  assign push             = accept && (!hex.ok || pending_r);
  assign push_token.err   = !hex.ok;
  assign push_token.value = {high_r, hex.nib};

  always_comb begin
    pending_nxt = pending_r;
    high_nxt    = high_r;
    if (accept) begin
      if (!hex.ok) begin
        pending_nxt = 1'b0;
      end else begin
        pending_nxt = !pending_r;
        if (!pending_r) begin
          high_nxt = hex.nib;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      high_r    <= 4'd0;
    end else begin
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

>>> hw/rtl/ahfd_queue.sv
module ahfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ahfd_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output ahfd_pkg::token_t pop_token,
  output logic             empty
);
  import ahfd_pkg::*;

  token_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign empty     = (count_r == '0);
  assign pop_token = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/ahfd_back.sv
module ahfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       max_length,
  input  logic              q_empty,
  input  ahfd_pkg::token_t  q_token,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ahfd_pkg::result_t out_result
);
  import ahfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] dcnt_r, dcnt_nxt;
  logic [15:0] count_r, count_nxt;
  logic [47:0] header_r, header_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r, res;
  logic        emit;
  logic        clear;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign pop        = !q_empty && (!out_valid_r || out_ready);
  assign b          = q_token.value;
  assign len_full   = {len_r[15:8], b};
  assign count_inc  = count_r + 16'd1;
  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    dcnt_nxt   = dcnt_r;
    count_nxt  = count_r;
    header_nxt = header_r;
    xor_nxt    = xor_r;
    emit       = 1'b0;
    clear      = 1'b0;
    res        = '0;

    if (pop) begin
      if (q_token.err) begin
        emit           = 1'b1;
        clear          = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_NON_HEX;
        res.last       = 1'b1;
      end else begin
        case (phase_r)
          PH_HUNT: begin
            if (b != START_BYTE) begin
              emit           = 1'b1;
              clear          = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_START;
              res.last       = 1'b1;
            end else begin
              phase_nxt = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_nxt   = {b, 8'd0};
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            if (len_full > max_length) begin
              emit           = 1'b1;
              clear          = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TOO_LONG;
              res.last       = 1'b1;
            end else begin
              len_nxt   = len_full;
              dcnt_nxt  = len_full - HEADER_BYTES;
              count_nxt = 16'd0;
              phase_nxt = PH_HEADER;
            end
          end
          PH_HEADER: begin
            header_nxt = {header_r[39:0], b};
            xor_nxt    = xor_r ^ b;
            count_nxt  = count_inc;
            if (count_inc >= HEADER_BYTES) begin
              count_nxt = 16'd0;
              phase_nxt = (len_r > HEADER_BYTES) ? PH_DATA : PH_CKSUM;
            end
          end
          PH_DATA: begin
            emit           = 1'b1;
            res.kind       = KIND_DATA;
            res.data_byte  = b;
            res.data_index = count_r;
            xor_nxt        = xor_r ^ b;
            count_nxt      = count_inc;
            if (count_inc >= dcnt_r) begin
              phase_nxt = PH_CKSUM;
            end
          end
          PH_CKSUM: begin
            emit             = 1'b1;
            clear            = 1'b1;
            res.api_id       = header_r[47:40];
            res.command      = header_r[39:32];
            res.status_code  = header_r[31:24];
            res.frame_number = header_r[23:16];
            res.option_word  = header_r[15:0];
            res.last         = 1'b1;
            if (xor_r == b) begin
              res.kind       = KIND_ACCEPT;
              res.error_code = ERR_NONE;
            end else begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_CHECKSUM;
            end
          end
          default: begin
            clear = 1'b1;
          end
        endcase
      end
    end

    if (clear) begin
      phase_nxt  = PH_HUNT;
      len_nxt    = 16'd0;
      dcnt_nxt   = 16'd0;
      count_nxt  = 16'd0;
      header_nxt = 48'd0;
      xor_nxt    = 8'd0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      len_r       <= 16'd0;
      dcnt_r      <= 16'd0;
      count_r     <= 16'd0;
      header_r    <= 48'd0;
      xor_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      dcnt_r      <= dcnt_nxt;
      count_r     <= count_nxt;
      header_r    <= header_nxt;
      xor_r       <= xor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/ascii_hex_frame_deframer.sv
// ASCII hex frame deframer.
// in_*  : one ASCII character per request. Hex digit pairs (either case) form
//         bytes: start byte 0xDE, 16-bit big-endian length, six header bytes,
//         length-6 data bytes, then an XOR checksum of header and data.
// out_* : one result per data byte (tuser = data), and one result closing each
//         frame (tlast high) that either accepts it or reports an error code.
// cfg_* : write-only max_length register (reset 256); write it while idle.
// Path: the front decodes and pairs nibbles into a four-entry queue as it
// accepts each character; the frame sequencer pops the head of the queue and
// loads the output register that drives out_*.
// Throughput: one character per cycle unless the output stalls; the sequencer
// handles one queued byte per cycle likewise; queue fill alone sets in_tready.
// Reset (synchronous rst_n low): parser hunts for a start byte, queue empty,
// output empty, max_length back to 256.
// Stall: while a result waits with out_tready low it holds; the sequencer stops,
// the queue fills, and in_tready drops once four bytes wait.
module ascii_hex_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] char_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] data_byte, [23:8] data_index, [31:24] api_id, [39:32] command,
  // [47:40] status_code, [55:48] frame_number, [71:56] option_word,
  // [74:72] error_code, [79:75] zero
  output logic [ahfd_pkg::TDATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,  // [1:0] kind
  output logic                          out_tlast,  // last
  input  logic                          cfg_wr_en,
  input  logic [15:0]                   cfg_wr_data // max_length
);
  import ahfd_pkg::*;

  logic [15:0] max_length_r;
  logic        q_full, q_empty, push, pop;
  token_t      push_token, pop_token;
  result_t     res;

  // Length limit; only the sequencer's length check reads it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // Decode characters, pair nibbles, flag bad characters.
  ahfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_char    (in_tdata),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .push       (push),
    .push_token (push_token)
  );

  // Decouple the character side from the result side.
  ahfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (pop),
    .pop_token  (pop_token),
    .empty      (q_empty)
  );

  // Walk the frame and hold the result for the receiver.
  ahfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_length (max_length_r),
    .q_empty    (q_empty),
    .q_token    (pop_token),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  assign out_tdata = {5'd0, res.error_code, res.option_word, res.frame_number,
                      res.status_code, res.command, res.api_id, res.data_index,
                      res.data_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

>>> hw/rtl/ahfd_checker.sv
module ahfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ahfd_pkg::TDATA_W-1:0] out_tdata,
  input logic [1:0]                    out_tuser,
  input logic                          out_tlast
);
  import ahfd_pkg::*;

  `include "ascii_hex_frame_deframer_assert.svh"

  `AHFD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `AHFD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result shown right after reset")
  `AHFD_ASSERT(a_last_kind, out_tvalid |-> (out_tlast == (out_tuser != KIND_DATA)), "tlast disagrees with kind")
  `AHFD_ASSERT(a_kind_code, out_tvalid |-> (out_tuser == KIND_ERROR) == (out_tdata[74:72] != ERR_NONE), "error code disagrees with kind")

endmodule

bind ascii_hex_frame_deframer ahfd_checker u_ahfd_checker (.*);

>>> test/ahfd_checker.sv
module ahfd_tb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [ahfd_pkg::TDATA_W-1:0] out_tdata,
  input  logic [1:0]                   out_tuser,
  input  logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data,
  output int                           fail_count,
  output int                           pending,
  output int                           results_seen,
  output int                           frames_ok,
  output int                           frames_bad
);
  import ahfd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT, ST_LEN_HI, ST_LEN_LO, ST_HEADER, ST_DATA, ST_CKSUM
  } parse_t;

  parse_t      stage;
  logic [3:0]  hi_nib;
  logic        nib_held;
  logic [15:0] frame_len;
  logic [15:0] byte_idx;
  logic [47:0] hdr_bytes;
  logic [7:0]  xor_sum;
  logic [15:0] max_len;

  result_t frame_results[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    frames_ok    = 0;
    frames_bad   = 0;
  end

  // bit 4 flags a character that is not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
    return 5'h10;
  endfunction

  function automatic void clear_parse();
    stage     = ST_HUNT;
    hi_nib    = '0;
    nib_held  = 1'b0;
    frame_len = '0;
    byte_idx  = '0;
    hdr_bytes = '0;
    xor_sum   = '0;
  endfunction

  function automatic result_t close_frame(input kind_t k, input err_t e, input bit with_hdr);
    result_t r;
    r = '0;
    r.kind = k;
    if (with_hdr) begin
      r.api_id       = hdr_bytes[47:40];
      r.command      = hdr_bytes[39:32];
      r.status_code  = hdr_bytes[31:24];
      r.frame_number = hdr_bytes[23:16];
      r.option_word  = hdr_bytes[15:0];
    end
    r.error_code = e;
    r.last       = 1'b1;
    clear_parse();
    return r;
  endfunction

  // Advance the parse by one character; return 1 when it yields a result.
  function automatic bit predict_char(input logic [7:0] c, output result_t r);
    logic [4:0]  hv;
    logic [7:0]  b;
    logic [15:0] payload;
    r  = '0;
    hv = nibble_of(c);
    if (hv[4]) begin
      r = close_frame(KIND_ERROR, ERR_NON_HEX, 1'b0);
      return 1'b1;
    end
    if (!nib_held) begin
      hi_nib   = hv[3:0];
      nib_held = 1'b1;
      return 1'b0;
    end
    nib_held = 1'b0;
    b        = {hi_nib, hv[3:0]};
    hi_nib   = '0;
    payload  = (frame_len >= HEADER_BYTES) ? frame_len - HEADER_BYTES : 16'd0;
    case (stage)
      ST_HUNT: begin
        if (b != START_BYTE) begin
          r = close_frame(KIND_ERROR, ERR_BAD_START, 1'b0);
          return 1'b1;
        end
        stage = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        frame_len = {b, 8'h00};
        stage     = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        frame_len[7:0] = b;
        if (frame_len > max_len) begin
          r = close_frame(KIND_ERROR, ERR_TOO_LONG, 1'b0);
          return 1'b1;
        end
        byte_idx = '0;
        stage    = ST_HEADER;
      end
      ST_HEADER: begin
        hdr_bytes = {hdr_bytes[39:0], b};
        xor_sum   = xor_sum ^ b;
        byte_idx  = byte_idx + 16'd1;
        if (byte_idx >= HEADER_BYTES) begin
          byte_idx = '0;
          stage    = (payload != 16'd0) ? ST_DATA : ST_CKSUM;
        end
      end
      ST_DATA: begin
        r.kind       = KIND_DATA;
        r.data_byte  = b;
        r.data_index = byte_idx;
        xor_sum      = xor_sum ^ b;
        byte_idx     = byte_idx + 16'd1;
        if (byte_idx >= payload) stage = ST_CKSUM;
        return 1'b1;
      end
      default: begin
        if (xor_sum == b) r = close_frame(KIND_ACCEPT, ERR_NONE, 1'b1);
        else r = close_frame(KIND_ERROR, ERR_CHECKSUM, 1'b1);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int field_diff(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    bit      has;
    int      bad;
    if (!rst_n) begin
      clear_parse();
      max_len = MAX_LENGTH_RESET;
      frame_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        has = predict_char(in_tdata, want);
        if (has) frame_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (frame_results.size() == 0) begin
          $error("result with nothing expected: kind %0d tdata 0x%0h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = frame_results.pop_front();
          if (want.kind == KIND_ACCEPT) frames_ok++;
          if (want.kind == KIND_ERROR) frames_bad++;
          bad = 0;
          bad += field_diff("kind", 16'(want.kind), 16'(out_tuser));
          bad += field_diff("data_byte", 16'(want.data_byte), 16'(out_tdata[7:0]));
          bad += field_diff("data_index", want.data_index, out_tdata[23:8]);
          bad += field_diff("api_id", 16'(want.api_id), 16'(out_tdata[31:24]));
          bad += field_diff("command", 16'(want.command), 16'(out_tdata[39:32]));
          bad += field_diff("status_code", 16'(want.status_code),
                            16'(out_tdata[47:40]));
          bad += field_diff("frame_number", 16'(want.frame_number),
                            16'(out_tdata[55:48]));
          bad += field_diff("option_word", want.option_word, out_tdata[71:56]);
          bad += field_diff("error_code", 16'(want.error_code), 16'(out_tdata[74:72]));
          bad += field_diff("last", 16'(want.last), 16'(out_tlast));
          bad += field_diff("tdata padding", 16'd0, 16'(out_tdata[79:75]));
          if (bad != 0) fail_count++;
        end
      end
      if (cfg_wr_en) max_len = cfg_wr_data;
    end
    pending <= frame_results.size();
  end

  final begin
    if (frame_results.size() != 0)
      $error("%0d expected results never arrived", frame_results.size());
  end

endmodule

>>> test/ascii_hex_frame_deframer_test.sv
module ascii_hex_frame_deframer_test;
  import ahfd_pkg::*;

  localparam int LIMIT     = 200000; // cycles before the run is declared hung
  localparam int LONG_HOLD = 300;    // output hold long enough to back up the input
  localparam int SETTLE    = 16;     // idle cycles after the last result arrives

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic [7:0]         in_tdata    = '0;
  logic               out_tready  = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [15:0]        cfg_wr_data = '0;
  logic               in_tready;
  logic               out_tvalid;
  logic [TDATA_W-1:0] out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;

  int tx_idle_pct  = 0; // chance per request that the sender goes quiet first
  int rx_stall_pct = 0; // chance per cycle that the receiver is not ready
  int hold_asked   = 0; // long output holds requested by the stimulus
  int hold_given   = 0; // long output holds started by the receiver
  int stall_left   = 0;
  int cycles       = 0;
  int chars_sent   = 0;

  int fail_count;
  int pending;
  int results_seen;
  int frames_ok;
  int frames_bad;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ascii_hex_frame_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ahfd_tb_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .frames_ok    (frames_ok),
    .frames_bad   (frames_bad)
  );

  // Receiver: random back-pressure, plus a long hold whenever the stimulus
  // asks for one. The hold is counted here so the sender keeps offering
  // characters the whole time and the block has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_given != hold_asked) begin
      out_tready <= 1'b0;
      stall_left <= LONG_HOLD;
      hold_given <= hold_given + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timed out after %0d cycles, %0d results still expected", LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hex digit in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // Any character outside the hex digits; the parser drops its frame on it.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
        (c >= 8'h61 && c <= 8'h66))
      c = c ^ 8'h80;
    return c;
  endfunction

  // Mostly short lengths, often right at the limit, rarely a longer run.
  function automatic logic [15:0] pick_len(input logic [15:0] maxl);
    int lim;
    int r;
    lim = (maxl > 16'd24) ? 24 : int'(maxl);
    r   = $urandom_range(99);
    if (maxl >= 16'd64 && r >= 97) return 16'($urandom_range(40, 64));
    if (r < 10) return 16'(lim);
    if (r < 25) return 16'($urandom_range(0, (lim < 5) ? lim : 5));
    return 16'($urandom_range(0, lim));
  endfunction

  // Offer one character and hold it until the request is taken. Valid stays
  // high into the next request unless the sender decides to go quiet.
  task automatic send_char(input logic [7:0] c);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_char(hex_char(b[7:4]));
    send_char(hex_char(b[3:0]));
  endtask

  // Send a whole frame. A corrupted checksum flips one bit of it. With
  // cut_at >= 0 the frame breaks off at that byte position with a stray
  // character, sometimes after half a byte.
  task automatic send_frame(input logic [15:0] len, input logic [47:0] hdr,
                            input bit bad_sum, input int cut_at);
    logic [7:0] b;
    logic [7:0] sum;
    int         n;
    sum = '0;
    n   = (len >= HEADER_BYTES) ? int'(len) - 6 : 0;
    for (int pos = 0; pos <= 9 + n; pos++) begin
      if (pos == cut_at) begin
        if ($urandom_range(1)) send_char(hex_char(4'($urandom_range(15))));
        send_char(junk_char());
        return;
      end
      if (pos == 0) b = START_BYTE;
      else if (pos == 1) b = len[15:8];
      else if (pos == 2) b = len[7:0];
      else if (pos <= 8) b = hdr[8*(8-pos) +: 8];
      else if (pos < 9 + n) b = 8'($urandom_range(255));
      else b = sum ^ (bad_sum ? 8'(1 << $urandom_range(7)) : 8'h00);
      if (pos >= 3 && pos < 9 + n) sum = sum ^ b;
      send_byte(b);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic: mostly well-formed frames with random content, the rest
  // oversize lengths, frames broken off midway and raw noise.
  task automatic run_phase(input int quota, input logic [15:0] maxl);
    int          start;
    int          r;
    int          excess;
    logic [15:0] len;
    start = chars_sent;
    while (chars_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 65) begin
        send_frame(pick_len(maxl), {16'($urandom), 32'($urandom)},
                   $urandom_range(9) == 0, -1);
      end else if (r < 75) begin
        if (maxl == 16'hFFFF) begin
          // nothing is too long here: start the longest frame and break it off
          send_frame(16'hFFFF, {16'($urandom), 32'($urandom)}, 1'b0,
                     $urandom_range(3, 14));
        end else begin
          excess = int'(maxl) + $urandom_range(1, 40);
          len    = (excess > 65535) ? 16'hFFFF : 16'(excess);
          if ($urandom_range(7) == 0) len = 16'hFFFF;
          send_byte(START_BYTE);
          send_byte(len[15:8]);
          send_byte(len[7:0]);
        end
      end else if (r < 85) begin
        len = pick_len(maxl);
        send_frame(len, {16'($urandom), 32'($urandom)}, 1'b0,
                   $urandom_range(1, (len > 6) ? 9 + int'(len) - 6 : 9));
      end else begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
        send_char(junk_char()); // resync
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: characters just outside each hex range and the extremes.
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h2F);
    send_char(8'h3A);
    send_char(8'h40);
    send_char(8'h47);
    send_char(8'h60);
    send_char(8'h67);
    // half a byte, then a stray character drops it
    send_char(8'h61);
    send_char(8'h7F);
    // wrong start byte
    send_byte(8'h00);
    // length one above the reset limit
    send_byte(START_BYTE);
    send_byte(8'h01);
    send_byte(8'h01);
    // length zero and length five: checksum right after the header
    send_frame(16'd0, 48'hFFFF_FFFF_FFFF, 1'b0, -1);
    send_frame(16'd5, 48'h0102_0304_0506, 1'b0, -1);
    // checksum mismatch on an all-zero header
    send_frame(16'd6, 48'h0, 1'b1, -1);
    // short payload
    send_frame(16'd8, 48'hA5A5_5A5A_00FF, 1'b0, -1);

    // Phase 1: widest limit, no idling, one long output hold.
    write_max(16'hFFFF);
    hold_asked <= hold_asked + 1;
    run_phase(420, 16'hFFFF);

    // Phase 2: zero limit, only empty frames pass; quiet sender.
    write_max(16'h0000);
    tx_idle_pct = 70;
    run_phase(280, 16'h0000);

    // Phase 3: small limit, heavy back-pressure and another long hold.
    write_max(16'd20);
    tx_idle_pct = 0;
    rx_stall_pct <= 70;
    hold_asked <= hold_asked + 1;
    run_phase(420, 16'd20);

    // Phase 4: back to the reset limit, light idling on both sides.
    write_max(MAX_LENGTH_RESET);
    tx_idle_pct = 15;
    rx_stall_pct <= 15;
    run_phase(420, MAX_LENGTH_RESET);

    drain();
    $display("checked %0d results from %0d characters: %0d frames accepted, %0d rejected",
             results_seen, chars_sent, frames_ok, frames_bad);
    $display("max_length stepped 256, 65535, 0, 20, 256 under four pacing mixes");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> ascii_hex_frame_deframer.f
+incdir+hw/rtl
hw/rtl/ahfd_pkg.sv
hw/rtl/ahfd_front.sv
hw/rtl/ahfd_queue.sv
hw/rtl/ahfd_back.sv
hw/rtl/ascii_hex_frame_deframer.sv
hw/rtl/ahfd_checker.sv
test/ahfd_checker.sv
test/ascii_hex_frame_deframer_test.sv
